@@ design/qau_pkg.sv @@
`default_nettype none

package qau_pkg;

   // Datapath sizing
   localparam int ACC_WIDTH = 32;
   localparam int FRAC_BITS = 24;
   localparam int IN_WIDTH  = 32;
   localparam int OUT_WIDTH = 64;

   // operand of the final power-of-two scale: holds x*26 and the hard sigmoid
   localparam int N_WIDTH = ((ACC_WIDTH + 5) > 34) ? (ACC_WIDTH + 5) : 34;
   // signed exponent of the final scale
   localparam int K_WIDTH = 8;
   localparam int SH_BITS = $clog2(OUT_WIDTH);

   // hard sigmoid raw value, signed working width and stored width
   localparam int HSIG_WIDTH = 34;
   localparam int H_WIDTH    = 33;

   // CSR port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACT_MODE         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_CUT        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HSIG_IN_SHIFT    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HSIG_OUT_SHIFT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HSWISH_OUT_SHIFT = 3'd4;

   // Activation kinds
   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_RELU   = 3'd1;
   localparam logic [2:0] MODE_RELU6  = 3'd2;
   localparam logic [2:0] MODE_LEAKY  = 3'd3;
   localparam logic [2:0] MODE_PASS   = 3'd4;
   localparam logic [2:0] MODE_HSIG   = 3'd5;
   localparam logic [2:0] MODE_HSWISH = 3'd6;

   // Arithmetic constants
   localparam logic signed [HSIG_WIDTH-1:0] HSIG_SCALE  = 34'sd2731;
   localparam logic signed [HSIG_WIDTH-1:0] HSIG_OFFSET = 34'sd8193;        // 3 * 2731
   localparam logic signed [HSIG_WIDTH-1:0] HSIG_LIMIT  = 34'sd4294967296;  // 2^32
   localparam logic [H_WIDTH-1:0]           H_LIMIT     = 33'h1_0000_0000;

   localparam logic signed [N_WIDTH-1:0] LEAKY_MUL   = N_WIDTH'(26);
   localparam logic signed [N_WIDTH-1:0] RELU6_VALUE = N_WIDTH'(6);

   localparam logic signed [K_WIDTH-1:0] K_FRAC      = K_WIDTH'(FRAC_BITS);
   localparam logic signed [K_WIDTH-1:0] K_ONE       = K_WIDTH'(1);
   localparam logic signed [K_WIDTH-1:0] K_LEAKY     = K_WIDTH'(9);   // 256 scale and extra halving
   localparam logic signed [K_WIDTH-1:0] K_HSIG_EXP  = K_WIDTH'(14);
   localparam logic signed [K_WIDTH-1:0] K_SHIFT_MAX = K_WIDTH'(OUT_WIDTH - 1);

   localparam logic signed [OUT_WIDTH-1:0] SAT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [OUT_WIDTH-1:0] SAT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

endpackage

`default_nettype wire

@@ design/qau_scale.sv @@
`default_nettype none

// Saturating power-of-two scale: floor(n * 2^k) clipped to the output range
module qau_scale import qau_pkg::*; (
   input  logic signed [N_WIDTH-1:0]   n,
   input  logic signed [K_WIDTH-1:0]   k,
   output logic signed [OUT_WIDTH-1:0] value
);

   localparam int S_WIDTH = N_WIDTH + OUT_WIDTH;
   localparam logic [SH_BITS-1:0] SH_MAX = SH_BITS'(OUT_WIDTH - 1);

   logic signed [K_WIDTH-1:0]       neg_k;
   logic [SH_BITS-1:0]              left_amt;
   logic [SH_BITS-1:0]              right_amt;
   logic signed [S_WIDTH-1:0]       wide;
   logic [S_WIDTH-OUT_WIDTH:0]      top;
   logic                            overflow;

   always_comb begin
      neg_k     = -k;
      // shifts past the word width only saturate or fill with sign
      left_amt  = (k > K_SHIFT_MAX) ? SH_MAX : k[SH_BITS-1:0];
      right_amt = (neg_k > K_SHIFT_MAX) ? SH_MAX : neg_k[SH_BITS-1:0];
      wide      = S_WIDTH'(n) <<< left_amt;
      // the sign bit and the bits above it must all agree
      top       = wide[S_WIDTH-1:OUT_WIDTH-1];
      overflow  = (|top) && !(&top);
      if (!k[K_WIDTH-1]) begin
         if (overflow) begin
            value = n[N_WIDTH-1] ? SAT_MIN : SAT_MAX;
         end else begin
            value = wide[OUT_WIDTH-1:0];
         end
      end else begin
         value = OUT_WIDTH'(n) >>> right_amt;
      end
   end

endmodule

`default_nettype wire

@@ design/quantized_activation_unit.sv @@
// Throughput: one word per cycle while the output is not stalled, set by the
// six register stages, each with its own valid bit; a stalled output lets
// bubbles ahead of it close up.
// Reset: synchronous, clears all CSRs to 0 and empties the pipeline.
// No memories, so no clearing pass after reset.
`default_nettype none

module quantized_activation_unit import qau_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [IN_WIDTH-1:0]         req_acc_value,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_WIDTH-1:0] rsp_act_value,
   // CSR write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int STAGES   = 6;
   localparam int RAW_WIDTH = (ACC_WIDTH > IN_WIDTH) ? ACC_WIDTH : IN_WIDTH;
   localparam int T_WIDTH  = ((ACC_WIDTH > 32) ? ACC_WIDTH : 32) + 2;
   localparam int C_WIDTH  = (ACC_WIDTH > 35) ? ACC_WIDTH : 35;
   localparam int HS_WIDTH = H_WIDTH + 7;

   // CSRs
   logic [2:0] act_mode_ff;
   logic [4:0] shift_cut_ff;
   logic [3:0] hsig_in_shift_ff;
   logic [4:0] hsig_out_shift_ff;
   logic [4:0] hswish_out_shift_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_mode_ff         <= MODE_NONE;
         shift_cut_ff        <= '0;
         hsig_in_shift_ff    <= '0;
         hsig_out_shift_ff   <= '0;
         hswish_out_shift_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ACT_MODE:         act_mode_ff         <= csr_data[2:0];
            CSR_SHIFT_CUT:        shift_cut_ff        <= csr_data[4:0];
            CSR_HSIG_IN_SHIFT:    hsig_in_shift_ff    <= csr_data[3:0];
            CSR_HSIG_OUT_SHIFT:   hsig_out_shift_ff   <= csr_data[4:0];
            CSR_HSWISH_OUT_SHIFT: hswish_out_shift_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control: a stage loads when empty or when it moves on
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int j = STAGES - 2; j >= 0; j--) begin
         en[j] = !valid_ff[j] || en[j+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int j = 1; j < STAGES; j++) begin
         valid_in[j] = en[j] ? valid_ff[j-1] : valid_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // Stage 0: capture the accumulator as a signed word
   logic [RAW_WIDTH-1:0]         raw_word;
   logic signed [ACC_WIDTH-1:0]  x0_in, x0_ff;

   always_comb begin
      raw_word = RAW_WIDTH'(req_acc_value);
      x0_in    = $signed(raw_word[ACC_WIDTH-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) x0_ff <= x0_in;
   end

   // Stage 1: round half up after the shift, clip to int8
   logic signed [T_WIDTH-1:0]    t_a, q_a;
   logic [5:0]                   rshift_a;
   logic signed [7:0]            r1_in, r1_ff;
   logic signed [ACC_WIDTH-1:0]  x1_ff;

   always_comb begin
      rshift_a = {1'b0, shift_cut_ff} + 6'd1;
      t_a      = T_WIDTH'(x0_ff) + (T_WIDTH'(1) << shift_cut_ff);
      q_a      = t_a >>> rshift_a;
      if (q_a > $signed(T_WIDTH'(127))) begin
         r1_in = 8'sd127;
      end else if (q_a < -$signed(T_WIDTH'(128))) begin
         r1_in = -8'sd128;
      end else begin
         r1_in = q_a[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         x1_ff <= x0_ff;
         r1_ff <= r1_in;
      end
   end

   // Stage 2: hard sigmoid raw value, and operand/exponent of the simple modes
   logic signed [HSIG_WIDTH-1:0] h_b;
   logic [H_WIDTH-1:0]           h2_in, h2_ff;
   logic signed [ACC_WIDTH-1:0]  xz_b;
   logic signed [K_WIDTH-1:0]    ks_b;
   logic signed [N_WIDTH-1:0]    nx2_in, nx2_ff;
   logic signed [K_WIDTH-1:0]    kx2_in, kx2_ff;
   logic signed [7:0]            r2_ff;

   always_comb begin
      h_b = HSIG_WIDTH'(r1_ff) * HSIG_SCALE + (HSIG_OFFSET <<< hsig_in_shift_ff);
      if (h_b < 0) begin
         h2_in = '0;
      end else if (h_b > HSIG_LIMIT) begin
         h2_in = H_LIMIT;
      end else begin
         h2_in = h_b[H_WIDTH-1:0];
      end

      xz_b = x1_ff[ACC_WIDTH-1] ? '0 : x1_ff;
      ks_b = $signed(K_WIDTH'(shift_cut_ff));
      case (act_mode_ff)
         MODE_NONE: begin
            nx2_in = N_WIDTH'(x1_ff);
            kx2_in = K_FRAC - ks_b;
         end
         MODE_RELU: begin
            nx2_in = N_WIDTH'(xz_b);
            kx2_in = K_FRAC - ks_b;
         end
         MODE_RELU6: begin
            // above six after the shift: clamp to exactly six
            if (C_WIDTH'(xz_b) > (C_WIDTH'(6) << shift_cut_ff)) begin
               nx2_in = RELU6_VALUE;
               kx2_in = K_FRAC;
            end else begin
               nx2_in = N_WIDTH'(xz_b);
               kx2_in = K_FRAC - ks_b;
            end
         end
         MODE_LEAKY: begin
            if (x1_ff[ACC_WIDTH-1]) begin
               nx2_in = N_WIDTH'(x1_ff) * LEAKY_MUL;
               kx2_in = K_FRAC - ks_b - K_LEAKY;
            end else begin
               nx2_in = N_WIDTH'(x1_ff);
               kx2_in = K_FRAC - ks_b - K_ONE;
            end
         end
         default: begin
            // pass and the unused code; hard sigmoid and swish are replaced in stage 4
            nx2_in = N_WIDTH'(x1_ff);
            kx2_in = K_FRAC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         h2_ff  <= h2_in;
         nx2_ff <= nx2_in;
         kx2_ff <= kx2_in;
         r2_ff  <= r1_ff;
      end
   end

   // Stage 3: hard sigmoid rounded half up to int8 (never negative)
   logic signed [K_WIDTH-1:0]    e_c, a_c;
   logic [HS_WIDTH-1:0]          hs_c;
   logic [6:0]                   g3_in, g3_ff;
   logic [H_WIDTH-1:0]           h3_ff;
   logic signed [N_WIDTH-1:0]    nx3_ff;
   logic signed [K_WIDTH-1:0]    kx3_ff;
   logic signed [7:0]            r3_ff;

   always_comb begin
      e_c  = $signed(K_WIDTH'(hsig_out_shift_ff)) - $signed(K_WIDTH'(hsig_in_shift_ff))
             - K_HSIG_EXP;
      a_c  = -e_c;
      hs_c = '0;
      if (h2_ff == '0) begin
         g3_in = '0;
      end else if (!e_c[K_WIDTH-1]) begin
         if (e_c >= $signed(K_WIDTH'(7))) begin
            g3_in = 7'd127;
         end else begin
            hs_c  = HS_WIDTH'(h2_ff) << e_c[2:0];
            g3_in = (hs_c > HS_WIDTH'(127)) ? 7'd127 : hs_c[6:0];
         end
      end else begin
         hs_c  = (HS_WIDTH'(h2_ff) + (HS_WIDTH'(1) << (a_c[5:0] - 6'd1))) >> a_c[5:0];
         g3_in = (hs_c > HS_WIDTH'(127)) ? 7'd127 : hs_c[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         g3_ff  <= g3_in;
         h3_ff  <= h2_ff;
         nx3_ff <= nx2_ff;
         kx3_ff <= kx2_ff;
         r3_ff  <= r2_ff;
      end
   end

   // Stage 4: hard swish product and final operand select
   logic signed [15:0]           p_d;
   logic signed [N_WIDTH-1:0]    n4_in, n4_ff;
   logic signed [K_WIDTH-1:0]    k4_in, k4_ff;

   always_comb begin
      p_d = 16'(r3_ff) * 16'($signed({1'b0, g3_ff}));
      case (act_mode_ff)
         MODE_HSIG: begin
            n4_in = $signed(N_WIDTH'(h3_ff));
            k4_in = K_FRAC + $signed(K_WIDTH'(hsig_out_shift_ff))
                    - $signed(K_WIDTH'(hsig_in_shift_ff)) - K_HSIG_EXP;
         end
         MODE_HSWISH: begin
            n4_in = N_WIDTH'(p_d);
            k4_in = K_FRAC + $signed(K_WIDTH'(hswish_out_shift_ff))
                    - $signed(K_WIDTH'(hsig_in_shift_ff))
                    - $signed(K_WIDTH'(hsig_out_shift_ff));
         end
         default: begin
            n4_in = nx3_ff;
            k4_in = kx3_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         n4_ff <= n4_in;
         k4_ff <= k4_in;
      end
   end

   // Stage 5: saturating scale into the output register
   logic signed [OUT_WIDTH-1:0]  act_value_in, act_value_ff;

   qau_scale u_scale (
      .n     (n4_ff),
      .k     (k4_ff),
      .value (act_value_in)
   );

   always_ff @(posedge clock) begin
      if (en[5]) act_value_ff <= act_value_in;
   end

   assign rsp_act_value = act_value_ff;

   // Checks
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted word did not enter stage 0");

   a_blocked_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !en[4]) |=> valid_ff[3])
      else $error("blocked word dropped from stage 3");

   a_hsig_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (h3_ff <= H_LIMIT))
      else $error("hard sigmoid raw value out of range");

   a_relu_nonneg: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[4] && (act_mode_ff == MODE_RELU || act_mode_ff == MODE_RELU6))
      |-> !n4_ff[N_WIDTH-1])
      else $error("negative operand in relu mode");

endmodule

`default_nettype wire

@@ sim/quantized_activation_unit_tb.sv @@
`default_nettype none

module quantized_activation_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qau_pkg::*;

   // mode 7 is not named in the package; it behaves as pass-through
   localparam logic [2:0] MODE_SPARE = 3'd7;
   localparam longint     I64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint     I64_MIN    = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
   localparam int         LONG_HOLD  = 300;
   localparam int         CYCLE_LIMIT = 500000;
   localparam int         RANDOM_WORDS = 1000;

   typedef struct {
      logic [IN_WIDTH-1:0]         acc;
      logic signed [OUT_WIDTH-1:0] act;
   } act_check_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [IN_WIDTH-1:0]         req_acc_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [OUT_WIDTH-1:0] rsp_act_value;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_data = '0;

   // local copy of the CSRs
   logic [2:0] cfg_mode      = '0;
   logic [4:0] cfg_shift     = '0;
   logic [3:0] cfg_hsig_in   = '0;
   logic [4:0] cfg_hsig_out  = '0;
   logic [4:0] cfg_hswish_out = '0;

   logic [IN_WIDTH-1:0] pending_acc[$];
   act_check_type       expected_act[$];

   bit   no_idle = 1'b0;
   bit   hold_used = 1'b0;
   logic [7:0] modes_seen = '0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   int   words_sent = 0;
   int   results = 0;
   int   err_cnt = 0;
   int   csr_writes = 0;
   int   settings = 0;
   int   cycles = 0;

   quantized_activation_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_acc_value (req_acc_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_act_value (rsp_act_value),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial forever #4 clock = ~clock;

   // floor(n * 2^k), saturated to 64 bits
   function automatic longint scale_by_pow2(longint n, int k);
      if (k == 0 || n == 0) return n;
      if (k > 0) begin
         if (k >= 63) return (n > 0) ? I64_MAX : I64_MIN;
         if (n > (I64_MAX >>> k)) return I64_MAX;
         if (n < -(longint'(1) <<< (63 - k))) return I64_MIN;
         return n <<< k;
      end
      if (-k >= 63) return (n < 0) ? -1 : 0;
      return n >>> (-k);
   endfunction

   function automatic longint clamp_int8(longint v);
      if (v > 127) return 127;
      if (v < -128) return -128;
      return v;
   endfunction

   // shifted input, rounded half up to int8
   function automatic longint round_to_int8(longint x, int s);
      return clamp_int8(scale_by_pow2(x + (longint'(1) <<< s), -(s + 1)));
   endfunction

   function automatic longint hard_sigmoid_raw(longint r, int i);
      longint h;
      h = r * 2731 + longint'(8193) * (longint'(1) <<< i);
      if (h < 0) h = 0;
      if (h > (longint'(1) <<< 32)) h = longint'(1) <<< 32;
      return h;
   endfunction

   // hard sigmoid rescaled by 2^e, rounded half up to int8
   function automatic longint round_sigmoid(longint h, int e);
      if (h == 0) return 0;
      if (e >= 0) begin
         if (e >= 7) return 127;
         return clamp_int8(h <<< e);
      end
      if (-e >= 40) return 0;
      return clamp_int8((h + (longint'(1) <<< (-e - 1))) >>> (-e));
   endfunction

   // activated value for one accumulator word under the current CSRs
   function automatic longint activate(logic [IN_WIDTH-1:0] acc);
      longint x;
      longint r;
      longint g;
      int s;
      int i;
      int o;
      int w;
      x = $signed(acc);
      s = cfg_shift;
      i = cfg_hsig_in;
      o = cfg_hsig_out;
      w = cfg_hswish_out;
      case (cfg_mode)
         MODE_NONE:  return scale_by_pow2(x, FRAC_BITS - s);
         MODE_RELU:  return scale_by_pow2((x < 0) ? 0 : x, FRAC_BITS - s);
         MODE_RELU6: begin
            if (x < 0) x = 0;
            if (x > (longint'(6) <<< s)) return scale_by_pow2(6, FRAC_BITS);
            return scale_by_pow2(x, FRAC_BITS - s);
         end
         MODE_LEAKY: begin
            if (x < 0) return scale_by_pow2(x * 26, FRAC_BITS - s - 9);
            return scale_by_pow2(x, FRAC_BITS - s - 1);
         end
         MODE_HSIG: begin
            r = round_to_int8(x, s);
            return scale_by_pow2(hard_sigmoid_raw(r, i), FRAC_BITS + o - i - 14);
         end
         MODE_HSWISH: begin
            r = round_to_int8(x, s);
            g = round_sigmoid(hard_sigmoid_raw(r, i), o - i - 14);
            return scale_by_pow2(r * g, FRAC_BITS + w - i - o);
         end
         default:    return scale_by_pow2(x, FRAC_BITS);
      endcase
   endfunction

   function automatic int idle_draw();
      if (no_idle) return 0;
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic int pick_field(int top);
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   // accumulator word biased towards the interesting regions for shift s
   function automatic logic [IN_WIDTH-1:0] draw_acc(int s);
      longint v;
      case ($urandom_range(0, 4))
         0: v = $urandom();
         1: begin
            // around zero at the scale of the shift; zero low bits hit the
            // round-half-up points
            v = (longint'($urandom_range(0, 600)) - 300) <<< s;
            if ($urandom_range(0, 1) == 1)
               v = v + (longint'($urandom()) & ((longint'(1) <<< s) - 1));
         end
         2: begin
            case ($urandom_range(0, 3))
               0: v = 64'sh7FFF_FFFF - $urandom_range(0, 3);
               1: v = -64'sh8000_0000 + $urandom_range(0, 3);
               2: v = (longint'(6) <<< s) + $urandom_range(0, 2) - 1;
               default: v = longint'($urandom_range(0, 2)) - 1;
            endcase
         end
         default: begin
            v = $urandom() >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
      endcase
      return IN_WIDTH'(v);
   endfunction

   // one CSR write; unused upper data bits sometimes carry noise
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input int value,
                            input int width);
      logic [CSR_DATA_WIDTH-1:0] data;
      data = CSR_DATA_WIDTH'(value);
      if ($urandom_range(0, 3) == 0) data = data | CSR_DATA_WIDTH'($urandom() << width);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ACT_MODE:         cfg_mode       = data[2:0];
         CSR_SHIFT_CUT:        cfg_shift      = data[4:0];
         CSR_HSIG_IN_SHIFT:    cfg_hsig_in    = data[3:0];
         CSR_HSIG_OUT_SHIFT:   cfg_hsig_out   = data[4:0];
         CSR_HSWISH_OUT_SHIFT: cfg_hswish_out = data[4:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_config(input logic [2:0] mode, input int s, input int i, input int o,
                             input int w);
      // occasionally poke an unused index as well
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_INDEX_WIDTH'($urandom_range(5, 7)), $urandom_range(0, 255), 0);
      write_csr(CSR_ACT_MODE, mode, 3);
      write_csr(CSR_SHIFT_CUT, s, 5);
      write_csr(CSR_HSIG_IN_SHIFT, i, 4);
      write_csr(CSR_HSIG_OUT_SHIFT, o, 5);
      write_csr(CSR_HSWISH_OUT_SHIFT, w, 5);
      settings++;
      @(negedge clock);
   endtask

   // wait until nothing is queued, offered or outstanding
   task automatic drain();
      do @(negedge clock);
      while (pending_acc.size() != 0 || req_valid || expected_act.size() != 0);
   endtask

   // sequence: directed corners, then random settings and words
   initial begin
      int random_words;
      int n;
      int s;
      random_words = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: plain shift by zero, input extremes
      pending_acc = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
      drain();
      set_config(MODE_RELU, 31, 0, 0, 0);
      pending_acc = {32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'h1};
      drain();
      // clamp at 6: exactly 6<<s, just above, negative, max
      set_config(MODE_RELU6, 3, 0, 0, 0);
      pending_acc = {32'd48, 32'd49, 32'hFFFF_FFF9, 32'h7FFF_FFFF};
      drain();
      set_config(MODE_LEAKY, 31, 0, 0, 0);
      pending_acc = {32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
      drain();
      // hard sigmoid: half rounding, int8 clamp, output saturation
      set_config(MODE_HSIG, 0, 0, 31, 0);
      pending_acc = {32'hFFFF_FFFF, 32'd255, 32'h8000_0000};
      drain();
      // hard swish: half points either side of zero, saturation at the top
      set_config(MODE_HSWISH, 1, 0, 0, 31);
      pending_acc = {32'd2, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000};
      drain();
      set_config(MODE_SPARE, 5, 0, 0, 0);
      pending_acc = {32'h8000_0000, 32'h7FFF_FFFF};
      drain();
      set_config(MODE_PASS, 31, 15, 31, 31);
      pending_acc = {32'hFFFF_FFFD};
      drain();

      // random settings, each followed by a batch of words
      while (random_words < RANDOM_WORDS) begin
         s = pick_field(31);
         set_config(3'($urandom_range(0, 7)), s, pick_field(15), pick_field(31),
                    pick_field(31));
         no_idle = ($urandom_range(0, 4) == 0);
         n = $urandom_range(20, 80);
         repeat (n) pending_acc.push_back(draw_acc(s));
         random_words += n;
         drain();
      end

      repeat (12) @(posedge clock);
      $display("%0d words sent, %0d checked under %0d CSR settings (%0d CSR writes)",
               words_sent, results, settings, csr_writes);
      $display("activation modes exercised %b, long output hold %s", modes_seen,
               hold_used ? "applied" : "not applied");
      if (err_cnt == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         // word taken: predict its activation under the current CSRs
         if (req_valid && !req_stall) begin
            expected_act.push_back('{acc: req_acc_value, act: activate(req_acc_value)});
            modes_seen[cfg_mode] <= 1'b1;
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_acc.size() != 0) begin
               req_valid     <= 1'b1;
               req_acc_value <= pending_acc.pop_front();
               send_gap      <= idle_draw();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and output stall
   always @(posedge clock) begin
      act_check_type want;
      int n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_act.size() == 0) begin
               err_cnt++;
               $display("%0t: unexpected act_value: expected none, got %h", $time,
                        rsp_act_value);
            end else begin
               want = expected_act.pop_front();
               if (rsp_act_value !== want.act) begin
                  err_cnt++;
                  $display("%0t: act_value for acc %h: expected %h, got %h", $time,
                           want.acc, want.act, rsp_act_value);
               end
            end
            results++;
         end
         // one long hold mid-run so the pipeline fills and stalls its input
         if (!hold_used && results >= 150 && pending_acc.size() > 20) begin
            hold_used <= 1'b1;
            rsp_stall <= 1'b1;
            hold_left <= LONG_HOLD;
         end else if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (rsp_valid && !rsp_stall) begin
            n = idle_draw();
            rsp_stall  <= (n != 0);
            stall_left <= (n > 0) ? n - 1 : 0;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

`default_nettype wire

@@ filelist.f @@
design/qau_pkg.sv
design/qau_scale.sv
design/quantized_activation_unit.sv
sim/quantized_activation_unit_tb.sv
